### rtl/core/xtnc_pkg.sv
`timescale 1ns / 1ps

package xtnc_pkg;

	localparam int MAX_DEPTH_DEF = 64;
	localparam int MAX_NAME_DEF  = 32;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_END    = 2'd1,
		MODE_SELF   = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_PUSHED     = 3'd0,
		KIND_END_MATCH  = 3'd1,
		KIND_ERR_END    = 3'd2,
		KIND_SELF_CLOSE = 3'd3,
		KIND_OVERFLOW   = 3'd4
	} kind_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] name_byte;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       popped;
		logic [6:0] depth;
	} out_t;

endpackage

### rtl/core/xml_tag_nesting_checker_top.sv
`timescale 1ns / 1ps

// XML tag nesting checker.
// Input channel (in_valid/in_ready/in_data) takes one tokenized name byte or
// one self-closing delimiter per transaction. Output channel
// (out_valid/out_ready/out_data) returns one result for each final name byte
// and each delimiter; other bytes and unused modes give no result.
// Throughput: one input transaction per cycle while in_ready is high. A result
// is registered into the output register, or into the skid entry while that holds a stalled one.
// The top-of-stack name byte and length for the next input are prefetched
// from two synchronous RAMs, addressed from the next stack depth and byte
// position, so each byte is checked in the cycle it is accepted.
// Results sit in an output register backed by one skid entry; in_ready only
// drops while both are full, so the input keeps moving while a result waits.
// When the receiver stalls, out_valid and out_data hold until taken.
// Reset clears the stack depth, name state and both result slots at once;
// the name RAMs need no clearing, since only pushed entries are ever read.
module xml_tag_nesting_checker_top
	import xtnc_pkg::*;
#(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int MAX_NAME  = MAX_NAME_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int PW = $clog2(MAX_NAME + 1);
	localparam int IW = $clog2(MAX_DEPTH);
	localparam int NW = $clog2(MAX_NAME);
	localparam int AW = $clog2(MAX_DEPTH * MAX_NAME);

	logic [DW-1:0] depth_q, depth_n, top_n;
	logic [PW-1:0] pos_q, pos_n, pos_inc, top_len;
	logic          match_q, match_n, match_c, match_bit;
	logic          long_q, long_n, long_c;
	logic          in_name, has_top, not_full;
	logic          accept, res_valid, out_pop;
	out_t          res, out_q, skid_q;
	logic          out_valid_q, skid_valid_q;

	logic          bwe, lwe;
	logic [AW-1:0] bwaddr, braddr;
	logic [IW-1:0] lwaddr, lraddr;
	logic [7:0]    brdata;
	logic [PW-1:0] lrdata;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign out_pop  = out_valid_q && out_ready;

	assign in_name   = pos_q < PW'(MAX_NAME);
	assign has_top   = depth_q != '0;
	assign not_full  = depth_q < DW'(MAX_DEPTH);
	assign top_len   = has_top ? lrdata : '0;
	assign pos_inc   = pos_q + PW'(1);
	assign match_bit = has_top && in_name && (pos_q < top_len)
		&& (brdata == in_data.name_byte);
	assign match_c   = match_q && match_bit;
	assign long_c    = long_q || !in_name;

	assign bwaddr = AW'(depth_q[IW-1:0]) * AW'(MAX_NAME) + AW'(pos_q[NW-1:0]);
	assign lwaddr = depth_q[IW-1:0];

	always_comb begin
		depth_n   = depth_q;
		pos_n     = pos_q;
		match_n   = match_q;
		long_n    = long_q;
		res_valid = 1'b0;
		res       = '0;
		bwe       = 1'b0;
		lwe       = 1'b0;
		if (accept) begin
			case (in_data.mode)
				MODE_SELF: begin
					pos_n     = '0;
					match_n   = 1'b1;
					long_n    = 1'b0;
					res_valid = 1'b1;
					res.kind  = KIND_SELF_CLOSE;
					if (has_top) begin
						depth_n    = depth_q - DW'(1);
						res.popped = 1'b1;
					end
				end
				MODE_START, MODE_END: begin
					bwe = in_name && not_full;
					if (!in_data.last) begin
						if (in_name) begin
							pos_n = pos_inc;
						end
						match_n = match_c;
						long_n  = long_c;
					end else begin
						pos_n     = '0;
						match_n   = 1'b1;
						long_n    = 1'b0;
						res_valid = 1'b1;
						if (long_c) begin
							res.kind = KIND_OVERFLOW;
						end else if (in_data.mode == MODE_START) begin
							if (!not_full) begin
								res.kind = KIND_OVERFLOW;
							end else begin
								lwe      = 1'b1;
								depth_n  = depth_q + DW'(1);
								res.kind = KIND_PUSHED;
							end
						end else if (match_c && (pos_inc == top_len)) begin
							depth_n    = depth_q - DW'(1);
							res.kind   = KIND_END_MATCH;
							res.popped = 1'b1;
						end else begin
							res.kind = KIND_ERR_END;
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.depth = 7'(depth_n);
	end

	// prefetch the top entry for the state the next transaction will see
	assign top_n  = depth_n - DW'(1);
	assign lraddr = top_n[IW-1:0];
	assign braddr = AW'(lraddr) * AW'(MAX_NAME) + AW'(pos_n[NW-1:0]);

	xtnc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_DEPTH * MAX_NAME)
	) u_name_ram (
		.clk  (clk),
		.we   (bwe),
		.waddr(bwaddr),
		.wdata(in_data.name_byte),
		.raddr(braddr),
		.rdata(brdata)
	);

	xtnc_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_DEPTH)
	) u_len_ram (
		.clk  (clk),
		.we   (lwe),
		.waddr(lwaddr),
		.wdata(pos_inc),
		.raddr(lraddr),
		.rdata(lrdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			pos_q        <= '0;
			match_q      <= 1'b1;
			long_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_n;
			pos_q   <= pos_n;
			match_q <= match_n;
			long_q  <= long_n;
			if (skid_valid_q) begin
				if (out_pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (res_valid) begin
				if (out_valid_q && !out_ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/xtnc_ram.sv
`timescale 1ns / 1ps

module xtnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first: a read of the address being written returns the new data
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/xtnc_checker.sv
`timescale 1ns / 1ps

module xtnc_checker
	import xtnc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// input only stalls when both result slots are occupied
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no pending result");

	a_popped_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.popped |->
			(out_data.kind == KIND_END_MATCH) || (out_data.kind == KIND_SELF_CLOSE))
		else $error("popped set on a non-popping result");

	// a self-closing transaction always leaves a result to show
	a_self_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.mode == MODE_SELF) |=> out_valid)
		else $error("no result after a self-closing transaction");

endmodule

bind xml_tag_nesting_checker_top xtnc_checker u_xtnc_checker (.*);

### tb/sv/tb_xml_tag_nesting_checker_top.sv
`timescale 1ns / 1ps

module tb_xml_tag_nesting_checker_top
	import xtnc_pkg::*;
;

	localparam int DEPTH_CAP   = MAX_DEPTH_DEF;
	localparam int NAME_CAP    = MAX_NAME_DEF;
	localparam int ITEMS       = 1050;
	localparam int LONG_HOLD   = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	typedef struct {
		in_t  d;
		bit   typed;
		bit   want;
		out_t res;
	} stim_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	xml_tag_nesting_checker_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// tag stack mirror
	logic [7:0] tag_bytes [DEPTH_CAP][NAME_CAP];
	int         tag_len [DEPTH_CAP];
	int         open_cnt   = 0;
	int         name_pos   = 0;
	bit         name_match = 1;
	bit         name_long  = 0;

	stim_t stim_q[$];
	out_t  pending_results[$];
	stim_t dir_rows[20];
	int    item_cnt  = 0;
	int    fed_cnt   = 0;
	int    err_cnt   = 0;
	int    fill_left = DEPTH_CAP + 2;
	bit    calm      = 0;
	bit    stim_done = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		if (err_cnt < 40)
			$display("MISMATCH at %0t: %s", $time, what);
		err_cnt++;
	endtask

	function automatic void track_tag(input in_t d, output bit has_res, output out_t res);
		int pos;
		int top_len;
		bit in_name;
		bit hit;
		bit matched;
		bit was_long;
		has_res = 0;
		res = '0;
		pos = name_pos;
		top_len = 0;
		hit = 0;
		if (d.mode == MODE_UNUSED)
			return;
		if (d.mode == MODE_SELF) begin
			name_pos = 0;
			name_match = 1;
			name_long = 0;
			has_res = 1;
			res.kind = KIND_SELF_CLOSE;
			res.popped = open_cnt > 0;
			if (open_cnt > 0)
				open_cnt--;
			res.depth = 7'(open_cnt);
			return;
		end
		in_name = pos < NAME_CAP;
		if (!in_name)
			name_long = 1;
		if (in_name && open_cnt < DEPTH_CAP)
			tag_bytes[open_cnt][pos] = d.name_byte;
		if (open_cnt > 0) begin
			top_len = tag_len[open_cnt - 1];
			if (in_name && pos < top_len)
				hit = tag_bytes[open_cnt - 1][pos] == d.name_byte;
		end
		name_match = name_match && hit;
		if (!d.last) begin
			if (in_name)
				name_pos = pos + 1;
			return;
		end
		was_long = name_long;
		matched = name_match && !was_long && (pos + 1) == top_len;
		name_pos = 0;
		name_match = 1;
		name_long = 0;
		has_res = 1;
		if (was_long) begin
			res.kind = KIND_OVERFLOW;
		end else if (d.mode == MODE_START) begin
			if (open_cnt >= DEPTH_CAP) begin
				res.kind = KIND_OVERFLOW;
			end else begin
				tag_len[open_cnt] = pos + 1;
				open_cnt++;
				res.kind = KIND_PUSHED;
			end
		end else if (matched) begin
			open_cnt--;
			res.kind = KIND_END_MATCH;
			res.popped = 1'b1;
		end else begin
			res.kind = KIND_ERR_END;
		end
		res.depth = 7'(open_cnt);
	endfunction

	function automatic stim_t tag_row(mode_t m, logic [7:0] b, logic l, bit typed,
			bit want = 0, kind_t k = KIND_PUSHED, logic p = 1'b0, logic [6:0] dp = '0);
		stim_t s;
		s.d.mode = m;
		s.d.name_byte = b;
		s.d.last = l;
		s.typed = typed;
		s.want = want;
		s.res.kind = k;
		s.res.popped = p;
		s.res.depth = dp;
		return s;
	endfunction

	task automatic queue_item(input mode_t m, input logic [7:0] b, input logic l);
		stim_q.push_back(tag_row(m, b, l, 0));
		if (m != MODE_UNUSED)
			item_cnt++;
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 4);
		if (r < 88)
			return $urandom_range(5, NAME_CAP - 1);
		if (r < 95)
			return NAME_CAP;
		return $urandom_range(NAME_CAP + 1, NAME_CAP + 8);
	endfunction

	task automatic send_name(input mode_t m, input logic [7:0] nm[$]);
		mode_t bm;
		for (int i = 0; i < nm.size(); i++) begin
			bm = m;
			if (i < nm.size() - 1 && $urandom_range(0, 19) == 0)
				bm = (m == MODE_START) ? MODE_END : MODE_START;
			if ($urandom_range(0, 29) == 0)
				queue_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			queue_item(bm, nm[i], i == nm.size() - 1);
		end
	endtask

	task automatic plan_next_tag();
		logic [7:0] nm[$];
		int pick;
		int push_w;
		int len;
		int idx;
		nm = {};
		pick = $urandom_range(0, 99);
		push_w = (open_cnt < 4) ? 55 : ((open_cnt > DEPTH_CAP - 8) ? 30 : 42);
		if (fill_left > 0) begin
			fill_left--;
			pick = 0;
		end else if ($urandom_range(0, 199) == 0) begin
			fill_left = DEPTH_CAP + 2 - open_cnt;
		end
		if (pick < push_w) begin
			len = pick_len();
			repeat (len) nm.push_back(8'($urandom_range(0, 255)));
			send_name(MODE_START, nm);
		end else if (pick < push_w + 41) begin
			if (pick >= push_w + 33) begin
				queue_item(MODE_SELF, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				return;
			end
			if (open_cnt > 0) begin
				for (int i = 0; i < tag_len[open_cnt - 1]; i++)
					nm.push_back(tag_bytes[open_cnt - 1][i]);
			end else begin
				repeat ($urandom_range(1, 4)) nm.push_back(8'($urandom_range(0, 255)));
			end
			send_name(MODE_END, nm);
		end else if (pick < push_w + 50) begin
			if (open_cnt > 0) begin
				for (int i = 0; i < tag_len[open_cnt - 1]; i++)
					nm.push_back(tag_bytes[open_cnt - 1][i]);
			end else begin
				repeat ($urandom_range(1, 4)) nm.push_back(8'($urandom_range(0, 255)));
			end
			case ($urandom_range(0, 2))
				0: begin
					idx = $urandom_range(0, nm.size() - 1);
					nm[idx] = nm[idx] ^ (8'd1 << $urandom_range(0, 7));
				end
				1: begin
					if (nm.size() > 1)
						void'(nm.pop_back());
					else
						nm.push_back(8'($urandom_range(0, 255)));
				end
				default: nm.push_back(8'($urandom_range(0, 255)));
			endcase
			send_name(MODE_END, nm);
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					repeat ($urandom_range(1, 5))
						queue_item(mode_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
					queue_item(MODE_SELF, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end
				1: queue_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				default: begin
					len = $urandom_range(NAME_CAP + 1, NAME_CAP + 8);
					repeat (len) nm.push_back(8'($urandom_range(0, 255)));
					send_name(MODE_END, nm);
				end
			endcase
		end
	endtask

	task automatic absorb(input stim_t s);
		bit has_res;
		out_t res;
		track_tag(s.d, has_res, res);
		if (s.typed) begin
			has_res = s.want;
			res = s.res;
		end
		if (has_res)
			pending_results.push_back(res);
		fed_cnt++;
		calm = (fed_cnt >= 500 && fed_cnt < 650) || item_cnt >= ITEMS - 150;
	endtask

	// input side
	initial begin : feed
		stim_t cur;
		int idle_left;
		idle_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (in_valid && in_ready)
				absorb(cur);
			if (!in_valid || in_ready) begin
				if (idle_left == 0 && !calm && $urandom_range(0, 11) == 0)
					idle_left = $urandom_range(1, 6);
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else begin
					if (stim_q.size() == 0 && item_cnt < ITEMS)
						plan_next_tag();
					if (stim_q.size() > 0) begin
						cur = stim_q.pop_front();
						in_valid <= 1'b1;
						in_data <= cur.d;
					end else begin
						in_valid <= 1'b0;
						stim_done = 1;
					end
				end
			end
		end
	end

	// output side, with one long hold-off to back up the block
	initial begin : drain
		int stall;
		bit held;
		stall = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && fed_cnt >= 300) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				if (stall == 0 && !calm && $urandom_range(0, 9) == 0)
					stall = $urandom_range(1, 6);
				if (stall > 0) begin
					stall--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d depth %0d",
					out_data.kind, out_data.depth));
			end else begin
				e = pending_results.pop_front();
				if (out_data.kind !== e.kind)
					flag_mismatch($sformatf("kind got %0d want %0d", out_data.kind, e.kind));
				if (out_data.popped !== e.popped)
					flag_mismatch($sformatf("popped got %0d want %0d", out_data.popped, e.popped));
				if (out_data.depth !== e.depth)
					flag_mismatch($sformatf("depth got %0d want %0d", out_data.depth, e.depth));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		dir_rows = '{
			tag_row(MODE_SELF,   8'h00, 1'b1, 1, 1, KIND_SELF_CLOSE, 1'b0, 7'd0),
			tag_row(MODE_END,    8'h61, 1'b1, 1, 1, KIND_ERR_END,    1'b0, 7'd0),
			tag_row(MODE_UNUSED, 8'hFF, 1'b1, 1),
			tag_row(MODE_START,  8'h00, 1'b1, 1, 1, KIND_PUSHED,     1'b0, 7'd1),
			tag_row(MODE_START,  8'hFF, 1'b0, 1),
			tag_row(MODE_START,  8'h80, 1'b1, 1, 1, KIND_PUSHED,     1'b0, 7'd2),
			tag_row(MODE_END,    8'hFF, 1'b0, 1),
			tag_row(MODE_END,    8'h7F, 1'b1, 1, 1, KIND_ERR_END,    1'b0, 7'd2),
			tag_row(MODE_END,    8'hFF, 1'b0, 1),
			tag_row(MODE_END,    8'h80, 1'b1, 1, 1, KIND_END_MATCH,  1'b1, 7'd1),
			tag_row(MODE_END,    8'h00, 1'b0, 1),
			tag_row(MODE_END,    8'h00, 1'b1, 1, 1, KIND_ERR_END,    1'b0, 7'd1),
			tag_row(MODE_START,  8'h55, 1'b0, 1),
			tag_row(MODE_SELF,   8'hAA, 1'b0, 1, 1, KIND_SELF_CLOSE, 1'b1, 7'd0),
			tag_row(MODE_END,    8'h41, 1'b0, 0),
			tag_row(MODE_START,  8'h42, 1'b1, 0),
			tag_row(MODE_START,  8'h41, 1'b0, 0),
			tag_row(MODE_END,    8'h42, 1'b1, 0),
			tag_row(MODE_UNUSED, 8'h00, 1'b0, 1),
			tag_row(MODE_SELF,   8'h00, 1'b1, 1, 1, KIND_SELF_CLOSE, 1'b0, 7'd0)
		};
		foreach (dir_rows[i]) begin
			stim_q.push_back(dir_rows[i]);
			item_cnt++;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_done && pending_results.size() == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/xtnc_pkg.sv
rtl/core/xtnc_ram.sv
rtl/core/xml_tag_nesting_checker_top.sv
rtl/core/xtnc_checker.sv
tb/sv/tb_xml_tag_nesting_checker_top.sv
